[sv/tlpt_pkg.sv]
// Package for the two-level page table engine: action and status codes,
// flag constants and field widths. No dependencies.
package tlpt_pkg;
    localparam int unsigned TABLES_DEF = 16;
    localparam int unsigned ENTRIES = 1024;
    localparam int unsigned IDX_W = 10;

    typedef enum logic [2:0] {
        ACT_XLATE = 3'd0, ACT_MAP4K = 3'd1, ACT_MAP4M = 3'd2,
        ACT_UNMAP4K = 3'd3, ACT_UNMAP4M = 3'd4
    } t_action;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_PHYS_MIS = 3'd1;
    localparam logic [2:0] ST_VIRT_MIS = 3'd2;
    localparam logic [2:0] ST_MAPPED = 3'd3;
    localparam logic [2:0] ST_LARGE = 3'd4;
    localparam logic [2:0] ST_UNMAPPED = 3'd5;
    localparam logic [2:0] ST_DIR_USED = 3'd6;
    localparam logic [2:0] ST_NO_TABLE = 3'd7;

    localparam logic [31:0] SMALL_K = 32'd3;
    localparam logic [31:0] SMALL_U = 32'd7;
    localparam logic [31:0] LARGE_K = 32'd131;
    localparam logic [31:0] LARGE_U = 32'd135;
    localparam logic [31:0] ADDR_MASK = 32'hFFFF_F000;
    localparam int unsigned LARGE_BIT = 7;

    localparam logic [0:0] CFG_LARGE = 1'd0;
    localparam logic [0:0] CFG_USER = 1'd1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;      // capture the request
        logic dir_rd;    // read directory entry
        logic tbl_rd;    // read table entry at request index
        logic dir_wr;    // write directory with dir_wdata
        logic [1:0] dir_sel; // 0 zero, 1 table ref, 2 large entry
        logic tbl_wr;    // write table entry
        logic [1:0] tbl_sel; // 0 zero, 1 page at pi, 2 fill at counter
        logic use_cnt;   // table address from sweep counter
        logic cnt_clr;
        logic cnt_inc;
        logic take;      // mark free table in use
        logic release_t; // free table of directory entry
        logic res_load;  // capture result
        logic [2:0] status;
        logic xlate;     // result from translation
    } t_cmd;

    typedef struct packed {
        t_action act;
        logic pa4k_mis;
        logic va4k_mis;
        logic pa4m_mis;
        logic va4m_mis;
        logic de_zero;
        logic de_large;
        logic tbl_ok;
        logic te_zero;
        logic free_ok;
        logic cnt_last;
        logic large_on;
    } t_sts;
endpackage

[sv/two_level_page_table_engine_top.sv]
// Top level of the two-level page table engine.
// Depends on tlpt_pkg, tlpt_ctrl, tlpt_datapath and tlpt_ram.
//
// Each request passes from acceptance to its offered result through a
// directory read, a dependent table read, a decision and the result hand-over,
// plus a sweep when a map takes a new table, which is cleared or filled one
// pool entry per cycle through the single pool port. A new request is taken
// no earlier than the cycle in which the previous result leaves. After reset
// the directory is cleared before requests are taken.
// s_tdata: action[2:0], vaddr[34:3], paddr[66:35].
module two_level_page_table_engine_top import tlpt_pkg::*; #(
    parameter int unsigned TABLES = TABLES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // action, vaddr, paddr
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // status, mapped, phys_result
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic        i_cfg_data
);
    logic r_large_on, r_user;
    t_cmd cmd;
    t_sts sts;
    logic clr_run;
    logic [IDX_W-1:0] clr_idx;
    logic [2:0] status;
    logic mapped;
    logic [31:0] phys;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_large_on <= 1'b0;
            r_user <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LARGE: r_large_on <= i_cfg_data;
                CFG_USER: r_user <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tlpt_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_tvalid), .o_in_ready(s_tready),
        .o_out_valid(m_tvalid), .i_out_ready(m_tready),
        .i_sts(sts), .o_cmd(cmd),
        .o_clear_run(clr_run), .o_clear_idx(clr_idx));

    tlpt_datapath #(.TABLES(TABLES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_action(s_tdata[2:0]), .i_va(s_tdata[34:3]), .i_pa(s_tdata[66:35]),
        .i_large_on(r_large_on), .i_user(r_user),
        .i_clear_run(clr_run), .i_clear_idx(clr_idx),
        .o_sts(sts), .o_status(status), .o_mapped(mapped), .o_phys(phys));

    assign m_tdata = {4'd0, phys, mapped, status};

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tready |-> !m_tvalid || m_tready)
        else $error("request taken while result blocked");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");
endmodule

[sv/tlpt_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
module tlpt_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule

[sv/tlpt_datapath.sv]
// Datapath: request registers, directory and pool memories, table allocator,
// sweep counter and result register. Depends on tlpt_pkg and tlpt_ram.
module tlpt_datapath import tlpt_pkg::*; #(
    parameter int unsigned TABLES = TABLES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [2:0]  i_action,
    input  logic [31:0] i_va,
    input  logic [31:0] i_pa,
    input  logic        i_large_on,
    input  logic        i_user,
    input  logic        i_clear_run,
    input  logic [IDX_W-1:0] i_clear_idx,
    output t_sts        o_sts,
    output logic [2:0]  o_status,
    output logic        o_mapped,
    output logic [31:0] o_phys
);
    localparam int unsigned TW = (TABLES > 1) ? $clog2(TABLES) : 1;
    localparam int unsigned PW = TW + IDX_W;

    logic [2:0]  r_act;
    logic [31:0] r_va, r_pa;
    logic [IDX_W-1:0] r_cnt;
    logic [TABLES-1:0] r_used;
    logic [TW-1:0] r_tsel;
    logic [2:0]  r_status;
    logic        r_mapped;
    logic [31:0] r_phys;

    logic [31:0] dir_q, tbl_q, dir_wd, tbl_wd, small_f, large_f;
    logic [IDX_W-1:0] di, pi;
    logic [PW-1:0] tbl_addr;
    logic [TW-1:0] free_t, de_t;
    logic free_ok, tbl_ok;

    assign di = r_va[31:22];
    assign pi = r_va[21:12];
    assign small_f = i_user ? SMALL_U : SMALL_K;
    assign large_f = i_user ? LARGE_U : LARGE_K;
    assign de_t = dir_q[12 +: TW];
    assign tbl_ok = ({12'd0, dir_q[31:12]} < 32'(TABLES));

    always_comb begin
        free_ok = 1'b0;
        free_t = '0;
        for (int i = TABLES - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_ok = 1'b1;
                free_t = TW'(i);
            end
        end
    end

    always_comb begin
        case (i_cmd.dir_sel)
            2'd1: dir_wd = {{(20-TW){1'b0}}, r_tsel, 12'd0} | small_f;
            2'd2: dir_wd = r_pa | large_f;
            default: dir_wd = '0;
        endcase
        case (i_cmd.tbl_sel)
            2'd1: tbl_wd = r_pa | small_f;
            2'd2: tbl_wd = (r_pa + {10'd0, r_cnt, 12'd0}) | small_f;
            default: tbl_wd = '0;
        endcase
    end

    // the table read follows the directory entry just read
    assign tbl_addr = {(i_cmd.tbl_rd ? de_t : r_tsel), (i_cmd.use_cnt ? r_cnt : pi)};

    tlpt_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_dir (
        .i_clk(i_clk), .i_we(i_clear_run || i_cmd.dir_wr),
        .i_addr(i_clear_run ? i_clear_idx : di),
        .i_wdata(i_clear_run ? 32'd0 : dir_wd), .o_rdata(dir_q));

    tlpt_ram #(.WIDTH(32), .DEPTH(TABLES * ENTRIES)) u_pool (
        .i_clk(i_clk), .i_we(i_cmd.tbl_wr), .i_addr(tbl_addr),
        .i_wdata(tbl_wd), .o_rdata(tbl_q));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_cnt <= '0;
        end else begin
            if (i_cmd.cnt_clr) r_cnt <= '0;
            else if (i_cmd.cnt_inc) r_cnt <= r_cnt + 1'b1;
            if (i_cmd.take) r_used[r_tsel] <= 1'b1;
            if (i_cmd.release_t && tbl_ok) r_used[de_t] <= 1'b0;
        end
        if (i_cmd.load) begin
            r_act <= i_action;
            r_va <= i_va;
            r_pa <= i_pa;
        end
        // table select: allocation on empty entry, else the entry's table
        if (i_cmd.dir_rd) r_tsel <= '0;
        else if (i_cmd.tbl_rd) r_tsel <= (dir_q == 32'd0) ? free_t : de_t;
        if (i_cmd.res_load) begin
            r_status <= i_cmd.status;
            r_mapped <= 1'b0;
            r_phys <= '0;
            if (i_cmd.xlate && dir_q != 32'd0) begin
                if (dir_q[LARGE_BIT]) begin
                    r_mapped <= 1'b1;
                    r_phys <= (dir_q & ADDR_MASK) + {10'd0, r_va[21:0]};
                end else if (tbl_ok && tbl_q != 32'd0) begin
                    r_mapped <= 1'b1;
                    r_phys <= (tbl_q & ADDR_MASK) + {20'd0, r_va[11:0]};
                end
            end
        end
    end

    always_comb begin
        o_sts.act = t_action'(r_act);
        o_sts.pa4k_mis = |r_pa[11:0];
        o_sts.va4k_mis = |r_va[11:0];
        o_sts.pa4m_mis = |r_pa[21:0];
        o_sts.va4m_mis = |r_va[21:0];
        o_sts.de_zero = (dir_q == 32'd0);
        o_sts.de_large = dir_q[LARGE_BIT];
        o_sts.tbl_ok = tbl_ok;
        o_sts.te_zero = (tbl_q == 32'd0);
        o_sts.free_ok = free_ok;
        o_sts.cnt_last = (r_cnt == IDX_W'(ENTRIES - 1));
        o_sts.large_on = i_large_on;
    end

    assign o_status = r_status;
    assign o_mapped = r_mapped;
    assign o_phys = r_phys;
endmodule

[sv/tlpt_ctrl.sv]
// Controller: request sequencing, decisions and table sweeps.
// Depends on tlpt_pkg.
module tlpt_ctrl import tlpt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_clear_run,
    output logic [IDX_W-1:0] o_clear_idx
);
    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_DIR, S_TBL, S_DEC, S_SWEEP, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic [IDX_W-1:0] r_cidx;
    logic r_fill, n_fill, r_ovalid;
    logic r_page;   // map 4K pending page write after clear

    assign o_clear_run = (r_state == S_CLEAR);
    assign o_clear_idx = r_cidx;
    assign o_in_ready = (r_state == S_IDLE) && (!r_ovalid || i_out_ready);
    assign o_out_valid = r_ovalid;

    always_comb begin
        o_cmd = '0;
        n_state = r_state;
        n_fill = r_fill;
        unique case (r_state)
            S_CLEAR: if (r_cidx == IDX_W'(ENTRIES - 1)) n_state = S_IDLE;
            S_IDLE: if (i_in_valid && o_in_ready) begin
                o_cmd.load = 1'b1;
                n_state = S_DIR;
            end
            S_DIR: begin
                o_cmd.dir_rd = 1'b1;
                n_state = S_TBL;
            end
            S_TBL: begin
                o_cmd.tbl_rd = 1'b1;
                n_state = S_DEC;
            end
            S_DEC: begin
                // directory entry and table entry are valid here
                o_cmd.res_load = 1'b1;
                o_cmd.status = ST_OK;
                n_state = S_DONE;
                unique case (i_sts.act)
                    ACT_XLATE: o_cmd.xlate = 1'b1;
                    ACT_MAP4K: begin
                        if (i_sts.pa4k_mis) o_cmd.status = ST_PHYS_MIS;
                        else if (i_sts.va4k_mis) o_cmd.status = ST_VIRT_MIS;
                        else if (i_sts.de_zero) begin
                            if (!i_sts.free_ok) o_cmd.status = ST_NO_TABLE;
                            else begin
                                o_cmd.take = 1'b1;
                                o_cmd.dir_wr = 1'b1;
                                o_cmd.dir_sel = 2'd1;
                                o_cmd.cnt_clr = 1'b1;
                                o_cmd.res_load = 1'b0;
                                n_fill = 1'b0;
                                n_state = S_SWEEP;
                            end
                        end else if (i_sts.de_large) o_cmd.status = ST_LARGE;
                        else if (!i_sts.tbl_ok) o_cmd.status = ST_UNMAPPED;
                        else if (!i_sts.te_zero) o_cmd.status = ST_MAPPED;
                        else begin
                            o_cmd.tbl_wr = 1'b1;
                            o_cmd.tbl_sel = 2'd1;
                        end
                    end
                    ACT_MAP4M: begin
                        if (i_sts.pa4m_mis) o_cmd.status = ST_PHYS_MIS;
                        else if (i_sts.va4m_mis) o_cmd.status = ST_VIRT_MIS;
                        else if (!i_sts.de_zero) o_cmd.status = ST_DIR_USED;
                        else if (i_sts.large_on) begin
                            o_cmd.dir_wr = 1'b1;
                            o_cmd.dir_sel = 2'd2;
                        end else if (!i_sts.free_ok) o_cmd.status = ST_NO_TABLE;
                        else begin
                            o_cmd.take = 1'b1;
                            o_cmd.dir_wr = 1'b1;
                            o_cmd.dir_sel = 2'd1;
                            o_cmd.cnt_clr = 1'b1;
                            o_cmd.res_load = 1'b0;
                            n_fill = 1'b1;
                            n_state = S_SWEEP;
                        end
                    end
                    ACT_UNMAP4K: begin
                        if (i_sts.va4k_mis) o_cmd.status = ST_VIRT_MIS;
                        else if (i_sts.de_zero) o_cmd.status = ST_OK;
                        else if (i_sts.de_large) o_cmd.status = ST_LARGE;
                        else if (!i_sts.tbl_ok || i_sts.te_zero)
                            o_cmd.status = ST_UNMAPPED;
                        else o_cmd.tbl_wr = 1'b1;
                    end
                    ACT_UNMAP4M: begin
                        if (i_sts.va4m_mis) o_cmd.status = ST_VIRT_MIS;
                        else if (i_sts.de_zero) o_cmd.status = ST_UNMAPPED;
                        else begin
                            o_cmd.release_t = !i_sts.de_large;
                            o_cmd.dir_wr = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            S_SWEEP: begin
                // clear or fill the new table one entry a cycle
                o_cmd.tbl_wr = 1'b1;
                o_cmd.use_cnt = 1'b1;
                o_cmd.tbl_sel = r_fill ? 2'd2 : 2'd0;
                o_cmd.cnt_inc = 1'b1;
                if (i_sts.cnt_last) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.status = ST_OK;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // after a map-4K clear, write the requested page into the table just cleared
                if (r_page) begin
                    o_cmd.tbl_wr = 1'b1;
                    o_cmd.tbl_sel = 2'd1;
                end
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cidx <= '0;
            r_fill <= 1'b0;
            r_ovalid <= 1'b0;
            r_page <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill <= n_fill;
            if (r_state == S_CLEAR) r_cidx <= r_cidx + 1'b1;
            if (r_state == S_SWEEP && i_sts.cnt_last && !r_fill) r_page <= 1'b1;
            else r_page <= 1'b0;
            if (r_state == S_DONE) r_ovalid <= 1'b1;
            else if (i_out_ready) r_ovalid <= 1'b0;
        end
    end
endmodule

[test/tb.sv]
// Testbench for two_level_page_table_engine_top: directed table then random requests,
// each result checked against a behavioural page table walker. Depends on tlpt_pkg and the top.
module tb;
    import tlpt_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic        i_cfg_data = 1'b0;

    two_level_page_table_engine_top dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    typedef struct packed {
        logic [2:0]  status;
        logic        mapped;
        logic [31:0] phys;
    } t_walk_res;

    typedef struct {
        logic [2:0]  act;
        logic [31:0] va;
        logic [31:0] pa;
        logic        known;  // expected result typed in below
        t_walk_res   res;
    } t_row;

    // walker copy of the block state
    logic [31:0] pd [ENTRIES];
    logic [31:0] pool [TABLES_DEF*ENTRIES];
    logic        busy_tbl [TABLES_DEF];
    logic        large_on, user_on;

    t_walk_res   pending [$];
    int          errors = 0;
    int          cycles = 0;
    int          hold_off = 0;

    function automatic int first_free();
        for (int i = 0; i < TABLES_DEF; i++) if (!busy_tbl[i]) return i;
        return -1;
    endfunction

    function automatic t_walk_res walk(logic [2:0] act, logic [31:0] va, logic [31:0] pa);
        t_walk_res r;
        logic [9:0]  di;
        logic [9:0]  pi;
        logic [31:0] de, sf, lf;
        int t;
        r = '0;
        di = va[31:22];
        pi = va[21:12];
        de = pd[di];
        sf = user_on ? SMALL_U : SMALL_K;
        lf = user_on ? LARGE_U : LARGE_K;
        t = (de[31:12] < TABLES_DEF) ? int'(de[31:12]) : -1;
        case (act)
            ACT_XLATE: begin
                if (de != 0) begin
                    if (de[LARGE_BIT]) begin
                        r.mapped = 1'b1;
                        r.phys = (de & ADDR_MASK) + {10'd0, va[21:0]};
                    end else if (t >= 0 && pool[t*ENTRIES+pi] != 0) begin
                        r.mapped = 1'b1;
                        r.phys = (pool[t*ENTRIES+pi] & ADDR_MASK) + {20'd0, va[11:0]};
                    end
                end
            end
            ACT_MAP4K: begin
                if (pa[11:0] != 0) r.status = ST_PHYS_MIS;
                else if (va[11:0] != 0) r.status = ST_VIRT_MIS;
                else if (de == 0) begin
                    t = first_free();
                    if (t < 0) r.status = ST_NO_TABLE;
                    else begin
                        for (int i = 0; i < ENTRIES; i++) pool[t*ENTRIES+i] = '0;
                        busy_tbl[t] = 1'b1;
                        pd[di] = (t << 12) | sf;
                        pool[t*ENTRIES+pi] = pa | sf;
                    end
                end else if (de[LARGE_BIT]) r.status = ST_LARGE;
                else if (t < 0) r.status = ST_UNMAPPED;
                else if (pool[t*ENTRIES+pi] != 0) r.status = ST_MAPPED;
                else pool[t*ENTRIES+pi] = pa | sf;
            end
            ACT_MAP4M: begin
                if (pa[21:0] != 0) r.status = ST_PHYS_MIS;
                else if (va[21:0] != 0) r.status = ST_VIRT_MIS;
                else if (de != 0) r.status = ST_DIR_USED;
                else if (large_on) pd[di] = pa | lf;
                else begin
                    t = first_free();
                    if (t < 0) r.status = ST_NO_TABLE;
                    else begin
                        busy_tbl[t] = 1'b1;
                        pd[di] = (t << 12) | sf;
                        for (int i = 0; i < ENTRIES; i++)
                            pool[t*ENTRIES+i] = (pa + i*4096) | sf;
                    end
                end
            end
            ACT_UNMAP4K: begin
                if (va[11:0] != 0) r.status = ST_VIRT_MIS;
                else if (de == 0) r.status = ST_OK;
                else if (de[LARGE_BIT]) r.status = ST_LARGE;
                else if (t < 0 || pool[t*ENTRIES+pi] == 0) r.status = ST_UNMAPPED;
                else pool[t*ENTRIES+pi] = '0;
            end
            ACT_UNMAP4M: begin
                if (va[21:0] != 0) r.status = ST_VIRT_MIS;
                else if (de == 0) r.status = ST_UNMAPPED;
                else begin
                    if (!de[LARGE_BIT] && t >= 0) busy_tbl[t] = 1'b0;
                    pd[di] = '0;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // valid stays high after acceptance unless a gap follows
    task automatic send_request(logic [2:0] act, logic [31:0] va, logic [31:0] pa,
                                bit known, t_walk_res res);
        t_walk_res w;
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, pa, va, act};
        w = walk(act, va, pa);
        if (known && w != res) begin
            $display("%0t table row disagrees with walker: typed %h walker %h", $time, res, w);
            errors++;
        end
        pending.push_back(known ? res : w);
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic write_reg(logic idx, logic val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        if (idx == CFG_LARGE) large_on = val; else user_on = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (1100) @(posedge i_clk);
    endtask

    // pick a random address from a few directory slots so maps and unmaps collide
    function automatic logic [31:0] pick_va(bit four_m);
        logic [31:0] v;
        v = {10'($urandom_range(0, 23)), 22'd0};
        if ($urandom_range(0, 9) == 0) v[31:22] = 10'($urandom);
        if (!four_m)
            v[21:12] = ($urandom_range(0, 3) == 0) ? 10'($urandom)
                                                   : 10'($urandom_range(0, 7));
        return v;
    endfunction

    // receiver: random stalls, plus one long hold-off
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) < 70);
        end
    end

    always @(posedge i_clk) begin
        t_walk_res got, want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = '{status: m_tdata[2:0], mapped: m_tdata[3], phys: m_tdata[35:4]};
            if (pending.size() == 0) begin
                $display("%0t unexpected result: expected none actual %h", $time, got);
                errors++;
            end else begin
                want = pending.pop_front();
                if (got.status != want.status) begin
                    $display("%0t status: expected %0d actual %0d", $time,
                             want.status, got.status);
                    errors++;
                end
                if (got.mapped != want.mapped) begin
                    $display("%0t mapped: expected %0d actual %0d", $time,
                             want.mapped, got.mapped);
                    errors++;
                end
                if (got.phys != want.phys) begin
                    $display("%0t phys_result: expected %h actual %h", $time,
                             want.phys, got.phys);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 5000000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    t_row rows [$];

    task automatic add_row(logic [2:0] a, logic [31:0] v, logic [31:0] p,
                           bit k = 0, logic [2:0] s = ST_OK, logic m = 0,
                           logic [31:0] ph = 0);
        t_row r;
        r.act = a; r.va = v; r.pa = p; r.known = k;
        r.res = '{status: s, mapped: m, phys: ph};
        rows.push_back(r);
    endtask

    initial begin
        logic [2:0]  a;
        logic [31:0] v, p;
        t_walk_res   none;
        none = '0;
        for (int i = 0; i < ENTRIES; i++) pd[i] = '0;
        for (int i = 0; i < TABLES_DEF*ENTRIES; i++) pool[i] = '0;
        for (int i = 0; i < TABLES_DEF; i++) busy_tbl[i] = 1'b0;
        large_on = 0;
        user_on = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_row(ACT_XLATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, ST_OK, 0, 0);
        add_row(ACT_XLATE, 32'h0, 32'h0, 1);
        add_row(ACT_UNMAP4K, 32'h0, 0, 1, ST_OK);
        add_row(ACT_UNMAP4M, 32'h0, 0, 1, ST_UNMAPPED);
        add_row(ACT_UNMAP4K, 32'h0000_0001, 0, 1, ST_VIRT_MIS);
        add_row(ACT_UNMAP4M, 32'h0000_1000, 0, 1, ST_VIRT_MIS);
        add_row(ACT_MAP4K, 32'h0, 32'h0000_0FFF, 1, ST_PHYS_MIS);
        add_row(ACT_MAP4K, 32'h0000_0800, 32'h0, 1, ST_VIRT_MIS);
        add_row(ACT_MAP4M, 32'h0, 32'h0000_1000, 1, ST_PHYS_MIS);
        add_row(ACT_MAP4M, 32'h0000_1000, 32'h0, 1, ST_VIRT_MIS);
        add_row(ACT_MAP4K, 32'hFFFF_F000, 32'hFFFF_F000);
        add_row(ACT_XLATE, 32'hFFFF_FFFF, 0);
        add_row(ACT_MAP4K, 32'hFFFF_F000, 32'h1000, 1, ST_MAPPED);
        add_row(ACT_UNMAP4K, 32'hFFFF_E000, 0, 1, ST_UNMAPPED);
        add_row(ACT_MAP4M, 32'hFFC0_0000, 32'h0, 1, ST_DIR_USED);
        add_row(ACT_MAP4M, 32'h0040_0000, 32'hFFC0_0000);
        add_row(ACT_XLATE, 32'h007F_FABC, 0);
        add_row(ACT_UNMAP4K, 32'hFFFF_F000, 0);
        add_row(ACT_UNMAP4M, 32'hFFC0_0000, 0);
        add_row(ACT_UNMAP4M, 32'h0040_0000, 0);
        add_row(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
        add_row(3'd7, 32'h1234_5000, 32'h0, 1);

        foreach (rows[i]) send_request(rows[i].act, rows[i].va, rows[i].pa,
                                       rows[i].known, rows[i].res);
        drain();

        // large pages with user flags: large entries, then unmap-4K on them
        write_reg(CFG_LARGE, 1'b1);
        write_reg(CFG_USER, 1'b1);
        send_request(ACT_MAP4M, 32'hFFC0_0000, 32'hFFC0_0000, 0, none);
        send_request(ACT_XLATE, 32'hFFFF_FFFF, 0, 1, '{ST_OK, 1'b1, 32'hFFFF_FFFF});
        send_request(ACT_UNMAP4K, 32'hFFC0_0000, 0, 1, '{ST_LARGE, 1'b0, 32'h0});
        send_request(ACT_MAP4K, 32'hFFC0_0000, 0, 1, '{ST_LARGE, 1'b0, 32'h0});
        drain();

        // exhaust the pool with large pages off, hit no-free-table, then unmap them all
        write_reg(CFG_LARGE, 1'b0);
        for (int i = 0; i < TABLES_DEF + 2; i++)
            send_request(ACT_MAP4K, {10'(100 + i), 22'd0}, 32'h0000_5000, 0, none);
        send_request(ACT_MAP4M, {10'd200, 22'd0}, 32'h0, 1, '{ST_NO_TABLE, 1'b0, 32'h0});
        for (int i = 0; i < TABLES_DEF + 2; i++)
            send_request(ACT_UNMAP4M, {10'(100 + i), 22'd0}, 0, 0, none);
        drain();

        // random phases over all register settings
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_LARGE, ph[0]);
            write_reg(CFG_USER, ph[1]);
            if (ph == 3) hold_off = 400;
            for (int n = 0; n < 100; n++) begin
                int k;
                k = $urandom_range(0, 99);
                if (k < 30) a = ACT_XLATE;
                else if (k < 50) a = ACT_MAP4K;
                else if (k < 62) a = ACT_MAP4M;
                else if (k < 78) a = ACT_UNMAP4K;
                else if (k < 96) a = ACT_UNMAP4M;
                else a = 3'($urandom_range(5, 7));
                v = pick_va(a == ACT_MAP4M || a == ACT_UNMAP4M);
                if (a == ACT_XLATE || $urandom_range(0, 19) == 0) v = $urandom;
                p = $urandom;
                if ($urandom_range(0, 9) != 0)
                    p = (a == ACT_MAP4M) ? {p[31:22], 22'd0} : {p[31:12], 12'd0};
                send_request(a, v, p, 0, none);
            end
            drain();
        end

        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
